[sv/mrd_pkg.sv]
// Package for the mount reply decoder: character codes, the result record
// and the hex digit decode function. No dependencies.
package mrd_pkg;

    // Character codes of the reply framing
    localparam logic [7:0] CHAR_GOOD  = 8'h3D;  // '='
    localparam logic [7:0] CHAR_ERROR = 8'h21;  // '!'
    localparam logic [7:0] CHAR_CR    = 8'h0D;  // carriage return

    // Width of the decoded value and its byte lanes
    localparam int VALUE_W = 24;
    localparam int LANES   = VALUE_W / 8;

    // Packed widths of the output channel
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // One decoded reply
    typedef struct packed {
        logic [VALUE_W-1:0] reply_value;
        logic [2:0]         char_count;
        logic               reply_good;
        logic               bad_digit;
        logic               overflow;
        logic               full_stop;
        logic               slewing;
        logic               slewing_to;
        logic               forward;
        logic               high_speed;
        logic               not_initialized;
    } t_result;

    // Hex digit decode: bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

[sv/mount_reply_decoder_top.sv]
// Mount reply decoder: collects reply bytes and emits one decoded reply per
// carriage return that closes an open reply. Depends on mrd_pkg.
//
//  Channel  | Direction | Ports              | Contents
//  ---------+-----------+--------------------+------------------------------------
//  s        | in        | tvalid/tready/tdata| one received byte
//  m        | out       | tvalid/tready/tdata| decoded reply value, count, flags
//           |           | tuser              | reply_good
//
// The parser state is updated in the cycle the request is accepted and a
// result is registered in the output stage, so one byte can be accepted in
// every cycle while o_s_tready is high. A two-entry output stage (output
// register plus skid register) keeps o_s_tready high while one result waits;
// it drops only while both entries are full. Reset (i_rst_n low, synchronous)
// clears the parser and empties the output stage.
module mount_reply_decoder_top #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input byte stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] rx_byte
    // Decoded replies
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [23:0] reply_value, [26:24] char_count, [27] bad_digit, [28] overflow,
    // [29] full_stop, [30] slewing, [31] slewing_to, [32] forward,
    // [33] high_speed, [34] not_initialized, [39:35] zero
    output logic [mrd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [mrd_pkg::M_TUSER_W-1:0]  o_m_tuser    // [0] reply_good
);
    import mrd_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);

    // Parser state
    logic          r_in_reply,   n_in_reply;
    logic          r_good,       n_good;
    logic [CW-1:0] r_chars,      n_chars;
    logic [3:0]    r_pending,    n_pending;
    logic [7:0]    r_lane [LANES];
    logic [7:0]    n_lane [LANES];
    logic [2:0]    r_first,      n_first;
    logic          r_second,     n_second;
    logic          r_third,      n_third;
    logic          r_bad,        n_bad;
    logic          r_ovf,        n_ovf;

    // Output stage
    logic          r_out_valid;
    t_result       r_out;
    logic          r_skid_valid;
    t_result       r_skid;

    logic          fire;
    logic          emit;
    t_result       res;
    logic [4:0]    hex;
    int unsigned   chars32;
    int unsigned   pair32;
    logic          stop;
    logic [7:0]    final_lane [LANES];

    assign o_s_tready = !r_skid_valid;
    assign fire       = i_s_tvalid && o_s_tready;
    assign hex        = hex_decode(i_s_tdata);
    assign chars32    = 32'(r_chars);
    assign pair32     = 32'(r_chars[CW-1:1]);

    // Byte parser: next state and result for the byte at the input
    always_comb begin
        n_in_reply = r_in_reply;
        n_good     = r_good;
        n_chars    = r_chars;
        n_pending  = r_pending;
        n_lane     = r_lane;
        n_first    = r_first;
        n_second   = r_second;
        n_third    = r_third;
        n_bad      = r_bad;
        n_ovf      = r_ovf;
        emit       = 1'b0;

        // Lanes as seen at close: a lone last digit forms its own pair
        final_lane = r_lane;
        for (int k = 0; k < LANES; k++) begin
            if (r_chars[0] && pair32 == k) begin
                final_lane[k] = {4'd0, r_pending};
            end
        end

        stop                = !r_second;
        res.reply_value     = {final_lane[2], final_lane[1], final_lane[0]};
        res.char_count      = (chars32 > 7) ? 3'd7 : chars32[2:0];
        res.reply_good      = r_good;
        res.bad_digit       = r_bad;
        res.overflow        = r_ovf;
        res.full_stop       = stop;
        res.slewing         = !stop && r_first[0];
        res.slewing_to      = !stop && !r_first[0];
        res.forward         = !r_first[1];
        res.high_speed      = r_first[2];
        res.not_initialized = !r_third;

        if (fire) begin
            if (i_s_tdata == CHAR_GOOD || i_s_tdata == CHAR_ERROR) begin
                // Start marker: opens a reply, or only updates the kind inside one
                if (!r_in_reply) begin
                    n_chars   = '0;
                    n_pending = '0;
                    for (int k = 0; k < LANES; k++) n_lane[k] = '0;
                    n_first   = '0;
                    n_second  = 1'b0;
                    n_third   = 1'b0;
                    n_bad     = 1'b0;
                    n_ovf     = 1'b0;
                    n_in_reply = 1'b1;
                end
                n_good = (i_s_tdata == CHAR_GOOD);
            end else if (r_in_reply) begin
                if (i_s_tdata == CHAR_CR) begin
                    // Close the reply and clear the payload
                    emit       = 1'b1;
                    n_in_reply = 1'b0;
                    n_chars    = '0;
                    n_pending  = '0;
                    for (int k = 0; k < LANES; k++) n_lane[k] = '0;
                    n_first    = '0;
                    n_second   = 1'b0;
                    n_third    = 1'b0;
                    n_bad      = 1'b0;
                    n_ovf      = 1'b0;
                end else if (chars32 >= MAX_DIGITS) begin
                    n_ovf = 1'b1;
                end else begin
                    // Payload character: status bits, nibble and pair assembly
                    if (hex[4]) begin
                        n_bad = 1'b1;
                    end
                    if (chars32 == 0) begin
                        n_first = i_s_tdata[2:0];
                    end else if (chars32 == 1) begin
                        n_second = i_s_tdata[0];
                    end else if (chars32 == 2) begin
                        n_third = i_s_tdata[0];
                    end
                    if (!r_chars[0]) begin
                        n_pending = hex[4] ? 4'd0 : hex[3:0];
                    end else begin
                        for (int k = 0; k < LANES; k++) begin
                            if (pair32 == k) begin
                                n_lane[k] = {r_pending, hex[4] ? 4'd0 : hex[3:0]};
                            end
                        end
                        n_pending = '0;
                    end
                    n_chars = r_chars + CW'(1);
                end
            end
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_reply <= 1'b0;
            r_good     <= 1'b0;
            r_chars    <= '0;
            r_pending  <= '0;
            for (int k = 0; k < LANES; k++) r_lane[k] <= '0;
            r_first    <= '0;
            r_second   <= 1'b0;
            r_third    <= 1'b0;
            r_bad      <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_in_reply <= n_in_reply;
            r_good     <= n_good;
            r_chars    <= n_chars;
            r_pending  <= n_pending;
            r_lane     <= n_lane;
            r_first    <= n_first;
            r_second   <= n_second;
            r_third    <= n_third;
            r_bad      <= n_bad;
            r_ovf      <= n_ovf;
        end
    end

    // Output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= emit;
            end
        end else if (emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the output stage
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (emit) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0,
                         r_out.not_initialized, r_out.high_speed, r_out.forward,
                         r_out.slewing_to, r_out.slewing, r_out.full_stop,
                         r_out.overflow, r_out.bad_digit,
                         r_out.char_count, r_out.reply_value};
    assign o_m_tuser  = r_out.reply_good;

endmodule

[dv/tb.sv]
// Self-checking testbench for mount_reply_decoder_top: byte-stream stimulus,
// a reply predictor and a field-by-field scoreboard. Depends on mrd_pkg and the RTL.

// Scoreboard: predicts decoded replies from accepted bytes and checks results
class reply_scoreboard #(int MAX_DIGITS = 6);

    // Parser copy
    bit          in_reply;
    bit          good_marker;
    int          chars_seen;
    logic [3:0]  pending_nibble;
    logic [23:0] value_acc;
    logic [2:0]  first_bits;
    logic        second_bit;
    logic        third_bit;
    bit          bad_seen;
    bit          overflow_seen;

    // Replies still to arrive, oldest first
    mrd_pkg::t_result replies_due[$];

    int failures;
    int bytes_used;
    int replies_checked;
    int error_replies;
    int bad_replies;
    int overflow_replies;

    function new();
        in_reply         = 0;
        good_marker      = 0;
        failures         = 0;
        bytes_used       = 0;
        replies_checked  = 0;
        error_replies    = 0;
        bad_replies      = 0;
        overflow_replies = 0;
        clear_payload();
    endfunction

    function void clear_payload();
        chars_seen     = 0;
        pending_nibble = 4'h0;
        value_acc      = 24'h0;
        first_bits     = 3'h0;
        second_bit     = 1'b0;
        third_bit      = 1'b0;
        bad_seen       = 0;
        overflow_seen  = 0;
    endfunction

    // Hex value of a character; bit 4 set when it is not a hex digit
    function logic [4:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        return 5'h10;
    endfunction

    // Byte lanes above the value width are dropped
    function void add_pair(int pair_index, logic [7:0] byte_val);
        if (pair_index < 3) begin
            value_acc = value_acc + (24'(byte_val) << (pair_index * 8));
        end
    endfunction

    // Advances the parser by one accepted request
    function void note_request(logic [7:0] c);
        mrd_pkg::t_result r;
        logic [4:0]       nib;
        logic             stop;
        if (c == mrd_pkg::CHAR_GOOD || c == mrd_pkg::CHAR_ERROR) begin
            if (!in_reply) begin
                clear_payload();
                in_reply = 1;
            end
            good_marker = (c == mrd_pkg::CHAR_GOOD);
            bytes_used++;
            return;
        end
        if (!in_reply) return;
        bytes_used++;

        // Carriage return closes the reply; a lone last digit is a pair of its own
        if (c == mrd_pkg::CHAR_CR) begin
            if (chars_seen % 2 == 1) add_pair(chars_seen / 2, {4'h0, pending_nibble});
            stop              = !second_bit;
            r.reply_value     = value_acc;
            r.char_count      = (chars_seen > 7) ? 3'd7 : 3'(chars_seen);
            r.reply_good      = good_marker;
            r.bad_digit       = bad_seen;
            r.overflow        = overflow_seen;
            r.full_stop       = stop;
            r.slewing         = !stop && first_bits[0];
            r.slewing_to      = !stop && !first_bits[0];
            r.forward         = !first_bits[1];
            r.high_speed      = first_bits[2];
            r.not_initialized = !third_bit;
            replies_due = {replies_due, r};
            in_reply = 0;
            clear_payload();
            return;
        end

        // Characters beyond the digit limit are dropped
        if (chars_seen >= MAX_DIGITS) begin
            overflow_seen = 1;
            return;
        end

        nib = nibble_of(c);
        if (nib[4]) begin
            bad_seen = 1;
            nib      = 5'h0;
        end
        if (chars_seen == 0) first_bits = c[2:0];
        else if (chars_seen == 1) second_bit = c[0];
        else if (chars_seen == 2) third_bit = c[0];

        if (chars_seen % 2 == 0) begin
            pending_nibble = nib[3:0];
        end else begin
            add_pair(chars_seen / 2, {pending_nibble, nib[3:0]});
            pending_nibble = 4'h0;
        end
        chars_seen++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            failures++;
        end
    endfunction

    // Checks one accepted reply against the oldest prediction
    function void check_reply(logic [39:0] tdata, logic [0:0] tuser);
        mrd_pkg::t_result e;
        if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply, actual tdata %0h tuser %0h", $time, tdata, tuser);
            failures++;
            return;
        end
        e = replies_due.pop_front();
        compare_field("reply_value", 32'(e.reply_value), 32'(tdata[23:0]));
        compare_field("char_count", 32'(e.char_count), 32'(tdata[26:24]));
        compare_field("reply_good", 32'(e.reply_good), 32'(tuser[0]));
        compare_field("bad_digit", 32'(e.bad_digit), 32'(tdata[27]));
        compare_field("overflow", 32'(e.overflow), 32'(tdata[28]));
        compare_field("full_stop", 32'(e.full_stop), 32'(tdata[29]));
        compare_field("slewing", 32'(e.slewing), 32'(tdata[30]));
        compare_field("slewing_to", 32'(e.slewing_to), 32'(tdata[31]));
        compare_field("forward", 32'(e.forward), 32'(tdata[32]));
        compare_field("high_speed", 32'(e.high_speed), 32'(tdata[33]));
        compare_field("not_initialized", 32'(e.not_initialized), 32'(tdata[34]));
        compare_field("tdata padding", 32'h0, 32'(tdata[39:35]));
        replies_checked++;
        if (!e.reply_good) error_replies++;
        if (e.bad_digit) bad_replies++;
        if (e.overflow) overflow_replies++;
    endfunction

    function void check_drained();
        if (replies_due.size() != 0) begin
            $display("%0t: %0d expected replies never arrived", $time, replies_due.size());
            failures++;
        end
    endfunction

endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    localparam int MAX_DIGITS  = 6;
    localparam int BYTE_TARGET = 1400;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata = 8'h00;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    int quiet_cycles = 0;
    int bytes_sent = 0;
    int s_gap_max = 3;
    int m_gap_max = 3;

    reply_scoreboard #(MAX_DIGITS) sb;

    mount_reply_decoder_top #(
        .MAX_DIGITS (MAX_DIGITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Handshake monitor: both channels sampled at the edge
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_tvalid && o_s_tready) sb.note_request(s_tdata);
            if (o_m_tvalid && m_tready) sb.check_reply(o_m_tdata, o_m_tuser);
        end
    end

    // Watchdog on cycles in which neither channel moves a request
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("mount_reply_decoder_top verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result sink with random back-pressure
    initial begin
        int gap;
        do @(posedge i_clk); while (!rst_n);
        forever begin
            gap = $urandom_range(0, m_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Sends one byte after a random gap and waits until it is accepted
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10) return 8'("0" + n);
        if ($urandom_range(0, 1) == 1) return 8'("A" + n - 10);
        return 8'("a" + n - 10);
    endfunction

    function automatic bit is_framing(logic [7:0] c);
        return c == CHAR_GOOD || c == CHAR_ERROR || c == CHAR_CR;
    endfunction

    // Any byte that is neither a hex digit nor a framing character
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_framing(c) || (c >= "0" && c <= "9") ||
                   (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
        return c;
    endfunction

    // One reply with random content, mostly well formed
    task automatic send_random_reply();
        int         lead;
        int         len;
        int         pick;
        logic [7:0] c;
        // Line noise before the marker, carriage returns included
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_GOOD || c == CHAR_ERROR);
            send_byte(c);
        end
        // Broken sequence: raw bytes, possibly leaving a reply open
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_byte(($urandom_range(0, 1) == 1) ? CHAR_GOOD : CHAR_ERROR);
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3)
                                          : $urandom_range(0, MAX_DIGITS);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) c = hex_char();
            else if (pick < 95) c = junk_char();
            else c = ($urandom_range(0, 1) == 1) ? CHAR_GOOD : CHAR_ERROR;
            send_byte(c);
        end
        send_byte(CHAR_CR);
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] directed[$];
        int         n_seq;
        sb = new();
        // Noise and a stray carriage return, a full overflowing reply with
        // every hex style, a marker inside a reply with bad digits, a lone
        // digit, an empty reply, and high-bit junk in an error reply
        directed = '{8'hFF, CHAR_CR,
                     CHAR_GOOD, "a", "B", "9", "0", "f", "F", "7", CHAR_CR,
                     CHAR_ERROR, "G", CHAR_GOOD, 8'h00, CHAR_CR,
                     CHAR_ERROR, "5", CHAR_CR,
                     CHAR_GOOD, CHAR_CR,
                     CHAR_ERROR, 8'h80, "e", CHAR_CR};

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_byte(directed[i]);

        // Random replies; idling changes every few dozen replies
        n_seq = 0;
        while (bytes_sent < BYTE_TARGET) begin
            if (n_seq % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        s_gap_max = 0;
                        m_gap_max = $urandom_range(0, 1) * 9;
                    end
                    1: begin
                        s_gap_max = 9;
                        m_gap_max = 0;
                    end
                    default: begin
                        s_gap_max = $urandom_range(0, 9);
                        m_gap_max = $urandom_range(0, 9);
                    end
                endcase
            end
            send_random_reply();
            n_seq++;
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding replies, then allow for stragglers
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.check_drained();

        $display("Sent %0d bytes, of which the parser took %0d; %0d replies checked,",
                 bytes_sent, sb.bytes_used, sb.replies_checked);
        $display("%0d error replies, %0d with bad digits and %0d overflowed.",
                 sb.error_replies, sb.bad_replies, sb.overflow_replies);
        if (sb.failures == 0) begin
            $display("mount_reply_decoder_top verification clean");
        end else begin
            $display("mount_reply_decoder_top verification failed");
        end
        $finish;
    end

endmodule
